/* sv/pgps_pkg.sv */
package pgps_pkg;

  // Default sizes for the top-level parameters
  localparam int DEF_NUM_GROUPS = 4;
  localparam int DEF_MAX_IDS    = 8;
  localparam int DEF_TIME_BITS  = 32;

  // Groups backed by configuration registers
  localparam int CFG_GROUPS = 4;

  // Field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ID_W       = 8;
  localparam int LEN_W      = 4;
  localparam int POS_W      = 3;
  localparam int IVL_W      = 16;
  localparam int SEL_W      = 2;
  localparam int LENS_W     = LEN_W * CFG_GROUPS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ID_TABLE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_TABLE1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID_TABLE2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID_TABLE3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTHS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVALS = 3'd5;

  // Configuration register file contents
  typedef struct packed {
    logic [CFG_GROUPS-1:0][CFG_DATA_W-1:0] id_table;
    logic [LENS_W-1:0]                     lengths;
    logic [CFG_DATA_W-1:0]                 intervals;
  } cfg_t;

endpackage

/* sv/pgps_if.sv */
// Input channel: one item per tick
interface pgps_in_if;
  logic valid;
  logic ready;
  logic enable;

  modport source (output valid, output enable, input ready);
  modport sink (input valid, input enable, output ready);
endinterface

// Result channel: one item per tick
interface pgps_out_if;
  import pgps_pkg::*;
  logic             valid;
  logic             ready;
  logic             issue;
  logic [SEL_W-1:0] group_sel;
  logic [ID_W-1:0]  query_id;
  logic             pass_done;

  modport source (output valid, output issue, output group_sel, output query_id,
                  output pass_done, input ready);
  modport sink (input valid, input issue, input group_sel, input query_id,
                input pass_done, output ready);
endinterface

// Configuration write channel
interface pgps_cfg_if;
  import pgps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

/* sv/pgps_cfg_regs.sv */
module pgps_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  pgps_cfg_if.sink       cfg,
  output pgps_pkg::cfg_t cfg_q
);
  import pgps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken
  assign cfg.ready = 1'b1;
  assign cfg_q     = cfg_r;

  // Register decode; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg.valid) begin
      unique case (cfg.idx) inside
        REG_ID_TABLE0, REG_ID_TABLE1, REG_ID_TABLE2, REG_ID_TABLE3: begin
          cfg_nxt.id_table[cfg.idx[1:0]] = cfg.data;
        end
        REG_LENGTHS: begin
          cfg_nxt.lengths = cfg.data[LENS_W-1:0];
        end
        REG_INTERVALS: begin
          cfg_nxt.intervals = cfg.data;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/pgps_pick.sv */
module pgps_pick #(
  parameter int NUM_GROUPS = pgps_pkg::DEF_NUM_GROUPS,
  parameter int TIME_BITS  = pgps_pkg::DEF_TIME_BITS
) (
  input  logic [TIME_BITS-1:0]                 now,
  input  logic [NUM_GROUPS-1:0][TIME_BITS-1:0] due,
  input  logic [NUM_GROUPS-1:0]                elig,
  output logic [NUM_GROUPS-1:0]                win_oh
);

  logic [NUM_GROUPS-1:0][TIME_BITS-1:0] late;
  logic [NUM_GROUPS-1:0]                ok;

  // Lateness per group; due means lateness below half the time span
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      late[g] = now - due[g];
      ok[g]   = elig[g] & ~late[g][TIME_BITS-1];
    end
  end

  // Pairwise compare: most overdue wins, ties to the lower group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      win_oh[g] = ok[g];
      for (int h = 0; h < NUM_GROUPS; h++) begin
        if (h < g) begin
          if (ok[h] && !(late[g] > late[h])) win_oh[g] = 1'b0;
        end else if (h > g) begin
          if (ok[h] && !(late[g] >= late[h])) win_oh[g] = 1'b0;
        end
      end
    end
  end

endmodule

/* sv/periodic_group_poll_scheduler_top.sv */
// Periodic group poll scheduler. Each input item is one tick; each tick yields
// exactly one result item. With enable set, the group whose due time is the
// most overdue (wrap-aware, ties to the lowest group) issues its next
// parameter ID and steps its list position round-robin; at the end of a pass
// its due time moves to now plus its interval. Throughput is one item per
// clock while the result side is not stalled: a tick enters an input register,
// the group pick and state update run in the work stage, and the result lands
// in an output register. The per-group state loop (due time, list position)
// closes within the work stage. Configuration writes are taken at any time and
// apply from the next tick on.
module periodic_group_poll_scheduler_top #(
  parameter int NUM_GROUPS = pgps_pkg::DEF_NUM_GROUPS,
  parameter int MAX_IDS    = pgps_pkg::DEF_MAX_IDS,
  parameter int TIME_BITS  = pgps_pkg::DEF_TIME_BITS
) (
  input logic         clk,
  input logic         rst_n,
  pgps_in_if.sink     in_ch,
  pgps_out_if.source  out_ch,
  pgps_cfg_if.sink    cfg_ch
);
  import pgps_pkg::*;

  cfg_t cfg_q;

  // Input register
  logic in_v_r;
  logic enable_r;
  logic adv;
  logic fire;

  // Scheduler state
  logic [TIME_BITS-1:0]                 now_r;
  logic [NUM_GROUPS-1:0][TIME_BITS-1:0] due_r;
  logic [NUM_GROUPS-1:0][TIME_BITS-1:0] due_nxt;
  logic [NUM_GROUPS-1:0][POS_W-1:0]     pos_r;
  logic [NUM_GROUPS-1:0][POS_W-1:0]     pos_nxt;

  // Per-group derived values
  logic [NUM_GROUPS-1:0][LEN_W-1:0] len;
  logic [NUM_GROUPS-1:0][POS_W-1:0] pos_eff;
  logic [NUM_GROUPS-1:0][LEN_W-1:0] step_pos;
  logic [NUM_GROUPS-1:0]            done;
  logic [NUM_GROUPS-1:0][ID_W-1:0]  id;
  logic [NUM_GROUPS-1:0][IVL_W-1:0] ivl;
  logic [NUM_GROUPS-1:0]            elig;
  logic [NUM_GROUPS-1:0]            win_oh;

  // Result
  logic             issue_nxt;
  logic [SEL_W-1:0] sel_nxt;
  logic [ID_W-1:0]  qid_nxt;
  logic             done_nxt;
  logic             out_v_r;
  logic             issue_r;
  logic [SEL_W-1:0] sel_r;
  logic [ID_W-1:0]  qid_r;
  logic             done_r;

  pgps_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_q (cfg_q)
  );

  // Handshake: the work stage advances when the result register is free
  assign adv         = !out_v_r || out_ch.ready;
  assign fire        = in_v_r && adv;
  assign in_ch.ready = !in_v_r || adv;

  // Per-group length, position, ID and interval
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    if (g < CFG_GROUPS) begin : g_cfg
      logic [LEN_W-1:0] nib;
      assign nib    = cfg_q.lengths[LEN_W*g +: LEN_W];
      assign len[g] = (nib > LEN_W'(MAX_IDS)) ? LEN_W'(MAX_IDS) : nib;
      assign id[g]  = cfg_q.id_table[g][ID_W*pos_eff[g] +: ID_W];
      assign ivl[g] = cfg_q.intervals[IVL_W*g +: IVL_W];
    end else begin : g_none
      assign len[g] = '0;
      assign id[g]  = '0;
      assign ivl[g] = '0;
    end
    assign pos_eff[g]  = ({1'b0, pos_r[g]} >= len[g]) ? '0 : pos_r[g];
    assign step_pos[g] = {1'b0, pos_eff[g]} + LEN_W'(1);
    assign done[g]     = step_pos[g] >= len[g];
    assign elig[g]     = enable_r && (len[g] != '0);
  end

  pgps_pick #(
    .NUM_GROUPS (NUM_GROUPS),
    .TIME_BITS  (TIME_BITS)
  ) u_pick (
    .now    (now_r),
    .due    (due_r),
    .elig   (elig),
    .win_oh (win_oh)
  );

  // Result fields from the winning group
  always_comb begin
    issue_nxt = |win_oh;
    sel_nxt   = '0;
    qid_nxt   = '0;
    done_nxt  = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (win_oh[g]) begin
        sel_nxt  = sel_nxt | SEL_W'(g);
        qid_nxt  = qid_nxt | id[g];
        done_nxt = done_nxt | done[g];
      end
    end
  end

  // Next position and due time of the winning group
  always_comb begin
    due_nxt = due_r;
    pos_nxt = pos_r;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (win_oh[g]) begin
        pos_nxt[g] = done[g] ? '0 : step_pos[g][POS_W-1:0];
        if (done[g]) begin
          due_nxt[g] = now_r + {{(TIME_BITS-IVL_W){1'b0}}, ivl[g]};
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      enable_r <= in_ch.enable;
    end
  end

  // Scheduler state, updated once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      due_r <= '0;
      pos_r <= '0;
    end else if (fire) begin
      now_r <= now_r + TIME_BITS'(1);
      due_r <= due_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      issue_r <= issue_nxt;
      sel_r   <= sel_nxt;
      qid_r   <= qid_nxt;
      done_r  <= done_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.issue     = issue_r;
  assign out_ch.group_sel = sel_r;
  assign out_ch.query_id  = qid_r;
  assign out_ch.pass_done = done_r;

endmodule

/* tb/poll_sched_checker.sv */
// Scoreboard for the poll scheduler: mirrors the register file and the
// per-group schedule, predicts one result per accepted tick and compares
// results in order.
module poll_sched_checker (
  input  logic clk,
  input  logic rst_n,
  pgps_in_if   in_ch,
  pgps_out_if  out_ch,
  pgps_cfg_if  cfg_ch,
  output int   mismatch_cnt,
  output int   n_waiting
);
  import pgps_pkg::*;

  localparam int TW      = DEF_TIME_BITS;
  localparam int NG      = DEF_NUM_GROUPS;
  localparam int MAX_LEN = DEF_MAX_IDS;

  typedef struct packed {
    logic             issue;
    logic [SEL_W-1:0] group_sel;
    logic [ID_W-1:0]  query_id;
    logic             pass_done;
  } poll_t;

  // Register mirror
  logic [CFG_DATA_W-1:0] id_tab [CFG_GROUPS];
  logic [LENS_W-1:0]     len_reg;
  logic [CFG_DATA_W-1:0] ivl_reg;

  // Schedule mirror
  logic [TW-1:0]    now_cnt;
  logic [TW-1:0]    due_at [CFG_GROUPS];
  logic [POS_W-1:0] cursor [CFG_GROUPS];

  poll_t poll_expect_q [$];
  int    errs;

  // Effective list length; groups past the register set count as empty
  function automatic int unsigned group_size(int g);
    int unsigned n;
    if (g >= CFG_GROUPS) return 0;
    n = len_reg[g*LEN_W +: LEN_W];
    return (n > MAX_LEN) ? MAX_LEN : n;
  endfunction

  // One tick: pick the most overdue non-empty group, issue, advance time
  function automatic poll_t serve_tick(input logic en);
    poll_t         r;
    logic [TW-1:0] late;
    logic [TW-1:0] best_late;
    int            best;
    bit            found;
    int unsigned   len;
    int unsigned   pos;
    int unsigned   nxt;
    r = '0;
    found = 1'b0;
    best = 0;
    best_late = '0;
    if (en) begin
      for (int g = 0; g < NG && g < CFG_GROUPS; g++) begin
        if (group_size(g) == 0) continue;
        late = now_cnt - due_at[g];
        // top bit set means the due time is still ahead
        if (late[TW-1]) continue;
        if (!found || late > best_late) begin
          found = 1'b1;
          best = g;
          best_late = late;
        end
      end
    end
    if (found) begin
      len = group_size(best);
      pos = cursor[best];
      if (pos >= len) pos = 0;
      nxt = pos + 1;
      r.pass_done = (nxt >= len);
      if (r.pass_done) begin
        nxt = 0;
        due_at[best] = now_cnt + TW'(ivl_reg[best*IVL_W +: IVL_W]);
      end
      cursor[best] = POS_W'(nxt);
      r.issue = 1'b1;
      r.group_sel = SEL_W'(best);
      r.query_id = id_tab[best][pos*ID_W +: ID_W];
    end
    now_cnt = now_cnt + 1'b1;
    return r;
  endfunction

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ID_TABLE0: id_tab[0] = val;
      REG_ID_TABLE1: id_tab[1] = val;
      REG_ID_TABLE2: id_tab[2] = val;
      REG_ID_TABLE3: id_tab[3] = val;
      REG_LENGTHS:   len_reg = val[LENS_W-1:0];
      REG_INTERVALS: ivl_reg = val;
      default: ;
    endcase
  endtask

  task automatic check_result(input poll_t got);
    poll_t want;
    if (poll_expect_q.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("%0t: unexpected result issue=%0b group=%0d id=%02h done=%0b",
                 $time, got.issue, got.group_sel, got.query_id, got.pass_done);
    end else begin
      want = poll_expect_q.pop_front();
      if (got.issue !== want.issue || got.group_sel !== want.group_sel ||
          got.query_id !== want.query_id || got.pass_done !== want.pass_done) begin
        errs++;
        if (errs <= 10)
          $display("%0t: issue/group/id/done exp %0b/%0d/%02h/%0b got %0b/%0d/%02h/%0b",
                   $time, want.issue, want.group_sel, want.query_id, want.pass_done,
                   got.issue, got.group_sel, got.query_id, got.pass_done);
      end
    end
  endtask

  // Results are taken before new ticks: latency keeps them apart, and
  // register writes act from the next tick on
  always @(posedge clk) begin : watch
    poll_t got;
    poll_t pred;
    if (!rst_n) begin
      for (int g = 0; g < CFG_GROUPS; g++) begin
        id_tab[g] = '0;
        due_at[g] = '0;
        cursor[g] = '0;
      end
      len_reg = '0;
      ivl_reg = '0;
      now_cnt = '0;
      errs = 0;
      poll_expect_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.issue = out_ch.issue;
        got.group_sel = out_ch.group_sel;
        got.query_id = out_ch.query_id;
        got.pass_done = out_ch.pass_done;
        check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = serve_tick(in_ch.enable);
        poll_expect_q.insert(poll_expect_q.size(), pred);
      end
      if (cfg_ch.valid && cfg_ch.ready)
        apply_write(cfg_ch.idx, cfg_ch.data);
    end
    mismatch_cnt <= errs;
    n_waiting <= poll_expect_q.size();
  end

endmodule

/* tb/tb_periodic_group_poll_scheduler_top.sv */
module tb_periodic_group_poll_scheduler_top;
  import pgps_pkg::*;

  localparam int LIMIT     = 200000;
  localparam int NREGS     = 6;
  localparam int NPHASES   = 8;
  localparam int PHASE_LEN = 50;
  localparam int STALL_AT  = 150;
  localparam int STALL_LEN = 250;

  logic clk;
  logic rst_n;
  int   cycle_cnt = 0;
  int   mismatch_cnt;
  int   n_waiting;
  int   in_gap_max;
  int   out_gap_max;

  // Register values for the next programming pass
  logic [CFG_DATA_W-1:0] id_set [CFG_GROUPS];
  logic [LENS_W-1:0]     len_set;
  logic [CFG_DATA_W-1:0] ivl_set;

  pgps_in_if  in_ch ();
  pgps_out_if out_ch ();
  pgps_cfg_if cfg_ch ();

  periodic_group_poll_scheduler_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  poll_sched_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .mismatch_cnt (mismatch_cnt),
    .n_waiting    (n_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one tick; valid stays high so back-to-back items need no toggle
  task automatic send_tick(input logic en);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.enable <= en;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write the selected registers from the staged values
  task automatic program_regs(input logic [NREGS-1:0] which);
    for (int g = 0; g < CFG_GROUPS; g++)
      if (which[REG_ID_TABLE0 + g])
        write_reg(CFG_IDX_W'(REG_ID_TABLE0 + g), id_set[g]);
    if (which[REG_LENGTHS]) write_reg(REG_LENGTHS, CFG_DATA_W'(len_set));
    if (which[REG_INTERVALS]) write_reg(REG_INTERVALS, ivl_set);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering and wait until every result is back, plus pipeline slack
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random lengths (some empty, some saturating) and mostly short intervals
  task automatic roll_settings();
    int k;
    for (int g = 0; g < CFG_GROUPS; g++) begin
      id_set[g] = rand_word();
      k = $urandom_range(0, 7);
      if (k == 0) len_set[g*LEN_W +: LEN_W] = '0;
      else if (k == 1) len_set[g*LEN_W +: LEN_W] = LEN_W'($urandom_range(9, 15));
      else len_set[g*LEN_W +: LEN_W] = LEN_W'($urandom_range(1, 8));
      k = $urandom_range(0, 5);
      ivl_set[g*IVL_W +: IVL_W] = (k == 0) ? '0 : IVL_W'($urandom_range(1, 40));
    end
  endtask

  // Result side: random stalls, plus one long hold-off to back up the block
  initial begin : result_sink
    int gap;
    int taken;
    bit stalled;
    taken = 0;
    stalled = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (taken == STALL_AT && !stalled) begin
        stalled = 1'b1;
        gap = STALL_LEN;
      end else begin
        gap = $urandom_range(0, out_gap_max);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Stimulus
  initial begin
    in_gap_max = 12;
    out_gap_max = 12;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.enable <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.idx <= REG_ID_TABLE0;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: every group empty, nothing may issue
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // All-ones and all-zero ID tables, full, saturating, single and empty
    // lengths, zero interval on group 1
    id_set[0] = '1;
    id_set[1] = 64'h0807_0605_0403_0201;
    id_set[2] = rand_word();
    id_set[3] = '0;
    len_set = 16'h01F8;
    ivl_set = {16'd2, 16'd3, 16'd0, 16'd5};
    program_regs('1);
    for (int i = 0; i < 22; i++)
      send_tick(i != 5 && i != 13);
    drain();

    // Shrink lengths under live positions
    len_set = 16'h1121;
    program_regs(NREGS'(1) << REG_LENGTHS);
    for (int i = 0; i < 6; i++)
      send_tick(1'b1);
    drain();

    // Random phases; first and last use extreme settings
    for (int p = 0; p < NPHASES; p++) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      roll_settings();
      if (p == 0) begin
        len_set = 16'h8888;
        ivl_set = '0;
        program_regs('1);
      end else if (p == NPHASES - 1) begin
        len_set = '1;
        ivl_set = '1;
        program_regs('1);
      end else begin
        program_regs(NREGS'($urandom_range(1, (1 << NREGS) - 1)));
      end
      for (int i = 0; i < PHASE_LEN; i++)
        send_tick($urandom_range(0, 4) != 0);
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pgps_pkg.sv
sv/pgps_if.sv
sv/pgps_cfg_regs.sv
sv/pgps_pick.sv
sv/periodic_group_poll_scheduler_top.sv
tb/poll_sched_checker.sv
tb/tb_periodic_group_poll_scheduler_top.sv
